>>> rtl/core/flp_pkg.sv
// ----------------------------------------------------------------------------
// flp_pkg
// Shared types and constants of the lens phase pixel pipeline.
// ----------------------------------------------------------------------------
package flp_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_FOCAL        = 3'd2,
        CFG_LENS_GAIN    = 3'd3,
        CFG_TILT_X       = 3'd4,
        CFG_TILT_Y       = 3'd5
    } t_cfg_index;

    localparam int CFG_DW   = 32;  // config write data width
    localparam int DIM_W    = 13;  // image dimension register width
    localparam int COORD_W  = 12;  // column and row width
    localparam int GAIN_W   = 32;  // Q16.16 gains and Q24.8 focal length
    localparam int TILT_W   = 24;  // tilt sum bits kept (phase bits 16..39)
    localparam int PATH_W   = 40;  // path bits kept, Q.16
    localparam int HALF_W   = 20;  // split of the path for the lens product
    localparam int PHASE_W  = 40;  // phase bits kept, Q.32
    localparam int LEVEL_W  = 8;   // output phase level

    localparam logic [DIM_W-1:0]  RST_WIDTH  = 13'd1920;
    localparam logic [DIM_W-1:0]  RST_HEIGHT = 13'd1152;
    localparam logic [GAIN_W-1:0] RST_FOCAL  = 32'd5565440;

endpackage

>>> rtl/core/flp_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// flp_sqrt_pipe
// Pipelined restoring integer square root, one root bit per stage, with a
// side payload carried alongside and a valid/ready chain that fills bubbles.
// ----------------------------------------------------------------------------
module flp_sqrt_pipe #(
    parameter int RW = 82,
    parameter int SW = 56
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [RW-1:0]       i_rad,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [RW/2-1:0]     o_root,
    output logic [SW-1:0]       o_side
);

    localparam int QW  = RW / 2;
    localparam int RMW = QW + 2;

    logic [QW-1:0]  r_valid;
    logic [RMW-1:0] r_rem  [QW];
    logic [QW-1:0]  r_root [QW];
    logic [RW-1:0]  r_rad  [QW];
    logic [SW-1:0]  r_side [QW];

    logic [QW-1:0]  w_ready;
    logic [QW-1:0]  w_vin;
    logic [RMW-1:0] w_rem_in  [QW];
    logic [QW-1:0]  w_root_in [QW];
    logic [RW-1:0]  w_rad_in  [QW];
    logic [SW-1:0]  w_side_in [QW];
    logic [RMW-1:0] n_rem  [QW];
    logic [QW-1:0]  n_root [QW];
    logic [RW-1:0]  n_rad  [QW];

    // stage inputs and ready chain
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                w_vin[k]     = i_valid;
                w_rem_in[k]  = '0;
                w_root_in[k] = '0;
                w_rad_in[k]  = i_rad;
                w_side_in[k] = i_side;
            end else begin
                w_vin[k]     = r_valid[k-1];
                w_rem_in[k]  = r_rem[k-1];
                w_root_in[k] = r_root[k-1];
                w_rad_in[k]  = r_rad[k-1];
                w_side_in[k] = r_side[k-1];
            end
        end
        w_ready[QW-1] = !r_valid[QW-1] || i_ready;
        for (int k = QW - 2; k >= 0; k--) begin
            w_ready[k] = !r_valid[k] || w_ready[k+1];
        end
    end

    // one root bit per stage
    always_comb begin
        logic [RMW-1:0] t_rem;
        logic [RMW-1:0] t_trial;
        for (int k = 0; k < QW; k++) begin
            t_rem   = {w_rem_in[k][RMW-3:0], w_rad_in[k][RW-1:RW-2]};
            t_trial = {w_root_in[k], 2'b01};
            n_rad[k] = {w_rad_in[k][RW-3:0], 2'b00};
            if (t_rem >= t_trial) begin
                n_rem[k]  = t_rem - t_trial;
                n_root[k] = {w_root_in[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k]  = t_rem;
                n_root[k] = {w_root_in[k][QW-2:0], 1'b0};
            end
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < QW; k++) begin
                if (w_ready[k]) begin
                    r_valid[k] <= w_vin[k];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            if (w_ready[k] && w_vin[k]) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_side[k] <= w_side_in[k];
            end
        end
    end

    assign o_ready = w_ready[0];
    assign o_valid = r_valid[QW-1];
    assign o_root  = r_root[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

>>> rtl/core/fresnel_lens_phase_pixel.sv
// ----------------------------------------------------------------------------
// fresnel_lens_phase_pixel
// Phase level of a lens-plus-tilt mask for one pixel of a phase modulator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid, i_column, i_row; the block drives o_in_stall.
//   Output channel: o_out_valid, o_phase_level; the receiver drives
//   i_out_stall. An item moves when valid is high and stall is low.
//   Config channel: i_cfg_valid, i_cfg_index, i_cfg_data, o_cfg_ready (always
//   high); write only while no item is in flight.
//   The pipeline has 3 front stages, 41 square root stages and 3 back
//   stages at the default MAX_DIM; the square root pipeline adds one stage
//   per root bit. Throughput is one pixel per clock when nothing stalls.
//   Every stage has its own valid bit and advances when its successor is
//   empty or moving, so a stall at the output fills the empty stages first
//   and then holds the input; nothing is lost or repeated.
//   Synchronous reset clears all valid bits and loads the register defaults:
//   1920 x 1152 pixels, focal length 5565440 (Q24.8), all gains zero.
// ----------------------------------------------------------------------------
module fresnel_lens_phase_pixel
    import flp_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [COORD_W-1:0] i_column,
    input  logic [COORD_W-1:0] i_row,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [LEVEL_W-1:0] o_phase_level,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [CFG_DW-1:0]  i_cfg_data
);

    localparam int DW   = $clog2(MAX_DIM) + 1;
    localparam int UW   = ((DW > COORD_W + 1) ? DW : COORD_W + 1) + 1;
    localparam int SQW  = 2 * UW;
    localparam int RW0  = ((2 * UW + 32 > 2 * GAIN_W + 16) ? 2 * UW + 32
                                                           : 2 * GAIN_W + 16) + 1;
    localparam int RW   = RW0 + (RW0 % 2);
    localparam int QW   = RW / 2;
    localparam int SW   = GAIN_W + TILT_W;

    // configuration registers
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [GAIN_W-1:0] r_focal;
    logic [GAIN_W-1:0] r_lens_gain;
    logic [GAIN_W-1:0] r_tilt_x;
    logic [GAIN_W-1:0] r_tilt_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_focal     <= RST_FOCAL;
            r_lens_gain <= '0;
            r_tilt_x    <= '0;
            r_tilt_y    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width     <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_height    <= i_cfg_data[DIM_W-1:0];
                CFG_FOCAL:        r_focal     <= i_cfg_data;
                CFG_LENS_GAIN:    r_lens_gain <= i_cfg_data;
                CFG_TILT_X:       r_tilt_x    <= i_cfg_data;
                CFG_TILT_Y:       r_tilt_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dimensions saturated to 1..MAX_DIM
    function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DW+DIM_W-1:0] t_d;
        t_d = (DW + DIM_W)'(d);
        if (d == '0) begin
            return DW'(1);
        end else if (t_d > (DW + DIM_W)'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(d);
        end
    endfunction

    logic [DW-1:0] w_wdim;
    logic [DW-1:0] w_hdim;
    assign w_wdim = clamp_dim(r_width);
    assign w_hdim = clamp_dim(r_height);

    // stage valid bits and ready chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6;
    logic w_sq_ready;
    logic w_sq_valid;

    assign w_rdy6 = !r_v6 || !i_out_stall;
    assign w_rdy5 = !r_v5 || w_rdy6;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_sq_ready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= w_sq_valid;
            if (w_rdy5) r_v5 <= r_v4;
            if (w_rdy6) r_v6 <= r_v5;
        end
    end

    // stage 1: centred offsets in half pitches
    logic signed [UW-1:0] r_u;
    logic signed [UW-1:0] r_v;
    logic signed [UW-1:0] n_u;
    logic signed [UW-1:0] n_v;

    assign n_u = UW'({i_column, 1'b0}) - UW'(w_wdim) + UW'(1);
    assign n_v = UW'({i_row, 1'b0}) - UW'(w_hdim) + UW'(1);

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in_valid) begin
            r_u <= n_u;
            r_v <= n_v;
        end
    end

    // stage 2: squares and tilt products
    logic [UW-1:0]          w_au;
    logic [UW-1:0]          w_av;
    logic [SQW-1:0]         r_usq;
    logic [SQW-1:0]         r_vsq;
    logic [2*GAIN_W-1:0]    r_fsq;
    logic [TILT_W-1:0]      r_tx;
    logic [TILT_W-1:0]      r_ty;
    logic signed [GAIN_W+UW-1:0] w_txp;
    logic signed [GAIN_W+UW-1:0] w_typ;

    assign w_au  = r_u[UW-1] ? UW'(-r_u) : UW'(r_u);
    assign w_av  = r_v[UW-1] ? UW'(-r_v) : UW'(r_v);
    assign w_txp = $signed(r_tilt_x) * r_u;
    assign w_typ = $signed(r_tilt_y) * r_v;

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_usq <= SQW'(w_au) * SQW'(w_au);
            r_vsq <= SQW'(w_av) * SQW'(w_av);
            r_fsq <= r_focal * r_focal;
            r_tx  <= w_txp[TILT_W-1:0];
            r_ty  <= w_typ[TILT_W-1:0];
        end
    end

    // stage 3: radicand and tilt sum
    logic [RW-1:0]     r_rad;
    logic [TILT_W-1:0] r_tilt;

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_rad  <= RW'({r_fsq, 16'b0}) + RW'({(SQW + 1)'(r_usq) + (SQW + 1)'(r_vsq),
                                                   32'b0});
            r_tilt <= r_tx + r_ty;
        end
    end

    // square root pipeline, focal length and tilt sum ride along
    logic [QW-1:0]     w_root;
    logic [SW-1:0]     w_side;

    flp_sqrt_pipe #(
        .RW (RW),
        .SW (SW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .o_ready (w_sq_ready),
        .i_rad   (r_rad),
        .i_side  ({r_focal, r_tilt}),
        .o_valid (w_sq_valid),
        .i_ready (w_rdy4),
        .o_root  (w_root),
        .o_side  (w_side)
    );

    // stage 4: lens path
    logic [PATH_W-1:0] r_path;
    logic [TILT_W-1:0] r_tilt4;

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && w_sq_valid) begin
            r_path  <= PATH_W'({w_side[SW-1:TILT_W], 8'b0}) - PATH_W'(w_root);
            r_tilt4 <= w_side[TILT_W-1:0];
        end
    end

    // stage 5: lens product in two halves
    logic signed [GAIN_W+HALF_W:0] w_mlo;
    logic signed [GAIN_W+HALF_W:0] w_mhi;
    logic [PHASE_W-1:0]            r_mlo;
    logic [HALF_W-1:0]             r_mhi;
    logic [TILT_W-1:0]             r_tilt5;

    assign w_mlo = $signed(r_lens_gain) * $signed({1'b0, r_path[HALF_W-1:0]});
    assign w_mhi = $signed(r_lens_gain) * $signed({1'b0, r_path[PATH_W-1:HALF_W]});

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r_v4) begin
            r_mlo   <= w_mlo[PHASE_W-1:0];
            r_mhi   <= w_mhi[HALF_W-1:0];
            r_tilt5 <= r_tilt4;
        end
    end

    // stage 6: phase sum, keep the wrapped level
    logic [PHASE_W-1:0] w_phase;
    logic [LEVEL_W-1:0] r_level;

    assign w_phase = r_mlo + {r_mhi, 20'b0} + {r_tilt5, 16'b0};

    always_ff @(posedge i_clk) begin
        if (w_rdy6 && r_v5) begin
            r_level <= w_phase[PHASE_W-1:PHASE_W-LEVEL_W];
        end
    end

    assign o_out_valid   = r_v6;
    assign o_phase_level = r_level;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lens-plus-tilt phase pixel pipeline: pixels are
// sent in random bursts, output stalls follow changing patterns, and every
// phase level is compared against a bit-exact fixed-point phase predictor.
// ----------------------------------------------------------------------------
module tb;
    import flp_pkg::*;

    localparam int  MAX_DIM      = 4096;
    localparam int  LATENCY      = 47 + 13;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  RANDOM_ITEMS = 1200;
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    // phase predictor and store of expected levels
    class phase_scoreboard;
        bit [DIM_W-1:0]         width_q;
        bit [DIM_W-1:0]         height_q;
        bit [GAIN_W-1:0]        focal_q;
        bit signed [GAIN_W-1:0] lens_q;
        bit signed [GAIN_W-1:0] tilt_x_q;
        bit signed [GAIN_W-1:0] tilt_y_q;
        bit [LEVEL_W-1:0]       level_q[$];
        int                     errors;
        int                     checked;

        function new();
            width_q  = RST_WIDTH;
            height_q = RST_HEIGHT;
            focal_q  = RST_FOCAL;
            lens_q   = '0;
            tilt_x_q = '0;
            tilt_y_q = '0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  width_q  = data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_q = data[DIM_W-1:0];
                CFG_FOCAL:        focal_q  = data;
                CFG_LENS_GAIN:    lens_q   = data;
                CFG_TILT_X:       tilt_x_q = data;
                CFG_TILT_Y:       tilt_y_q = data;
                default: ;
            endcase
        endfunction

        // dimension saturated to 1..MAX_DIM
        function int clamp_dim(bit [DIM_W-1:0] d);
            if (d < 1) return 1;
            if (d > MAX_DIM) return MAX_DIM;
            return int'(d);
        endfunction

        // floor square root of a 128-bit radicand
        function bit [63:0] floor_sqrt(bit [127:0] x);
            bit [127:0] rem;
            bit [127:0] trial;
            bit [63:0]  root;
            rem  = '0;
            root = '0;
            for (int i = 63; i >= 0; i--) begin
                rem   = (rem << 2) | ((x >> (2 * i)) & 128'd3);
                trial = ({64'b0, root} << 2) | 128'd1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[62:0], 1'b1};
                end else begin
                    root = root << 1;
                end
            end
            return root;
        endfunction

        function bit [LEVEL_W-1:0] predict(bit [COORD_W-1:0] col, bit [COORD_W-1:0] row);
            longint     u;
            longint     v;
            bit [63:0]  rsq;
            bit [63:0]  ff;
            bit [63:0]  f2;
            bit [127:0] rad;
            bit [63:0]  root;
            longint     path;
            longint     phase;
            u     = 2 * longint'(col) - (clamp_dim(width_q) - 1);
            v     = 2 * longint'(row) - (clamp_dim(height_q) - 1);
            rsq   = u * u + v * v;
            ff    = focal_q;
            f2    = ff * ff;
            rad   = ({64'b0, f2} << 16) + ({64'b0, rsq} << 32);
            root  = floor_sqrt(rad);
            path  = (longint'(ff) << 8) - longint'(root);
            phase = longint'(lens_q) * path + ((longint'(tilt_x_q) * u) << 16)
                  + ((longint'(tilt_y_q) * v) << 16);
            return phase[39:32];
        endfunction

        function void note_pixel(bit [COORD_W-1:0] col, bit [COORD_W-1:0] row);
            level_q.push_back(predict(col, row));
        endfunction

        function void check_level(bit [LEVEL_W-1:0] got);
            bit [LEVEL_W-1:0] exp_level;
            if (level_q.size() == 0) begin
                report($sformatf("unexpected level %0d", got));
                return;
            end
            exp_level = level_q.pop_front();
            checked++;
            if (got !== exp_level)
                report($sformatf("phase_level got %0d want %0d", got, exp_level));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [COORD_W-1:0] i_column;
    logic [COORD_W-1:0] i_row;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [LEVEL_W-1:0] o_phase_level;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [CFG_DW-1:0]  i_cfg_data;

    phase_scoreboard sb = new();
    int  cycle_count = 0;
    int  stall_mode  = 0;
    bit  hold_req    = 0;
    int  hold_left   = 0;
    int  cfg_writes  = 0;

    fresnel_lens_phase_pixel #(.MAX_DIM(MAX_DIM)) dut (.*);

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_req  <= 1'b0;
            hold_left <= 300;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= cycle_count[2];
            endcase
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_level(o_phase_level);
    end

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        i_in_valid <= 1'b1;
        i_column   <= col;
        i_row      <= row;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(col, row);
    endtask

    task automatic pause_input(input int gap);
        i_in_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // wait for the pipeline to drain
    task automatic drain();
        pause_input(1);
        while (sb.level_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic set_all(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                           input logic [CFG_DW-1:0] f, input logic [CFG_DW-1:0] lg,
                           input logic [CFG_DW-1:0] tx, input logic [CFG_DW-1:0] ty);
        write_cfg(CFG_IMAGE_WIDTH, w);
        write_cfg(CFG_IMAGE_HEIGHT, h);
        write_cfg(CFG_FOCAL, f);
        write_cfg(CFG_LENS_GAIN, lg);
        write_cfg(CFG_TILT_X, tx);
        write_cfg(CFG_TILT_Y, ty);
    endtask

    // corner and centre pixels
    task automatic send_corners();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'(sb.clamp_dim(sb.width_q) / 2), 12'(sb.clamp_dim(sb.height_q) / 2));
    endtask

    function automatic logic [CFG_DW-1:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return 4096;
            4: return 32'h1FFF;
            5: return $urandom_range(4097, 8191);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] pick_focal();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            3: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent;
        int phase_cnt;
        int burst;
        int wmax;
        int hmax;
        i_rst_n     = 1'b0;
        i_clk       = 1'b0;
        i_in_valid  = 1'b0;
        i_column    = '0;
        i_row       = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        sent        = 0;
        phase_cnt   = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults, then extreme settings
        send_corners();
        drain();
        write_cfg(CFG_LENS_GAIN, 32'h0001_0000);
        send_corners();
        drain();
        set_all(0, 32'h1FFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
        write_cfg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_cfg(CFG_SPARE_B, 32'h1234_5678);
        send_corners();
        drain();
        set_all(4096, 1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        stall_mode = 3;
        send_corners();
        drain();

        // random phases
        while (sent < RANDOM_ITEMS) begin
            set_all(pick_dim(), pick_dim(), pick_focal(), pick_gain(), pick_gain(), pick_gain());
            stall_mode = phase_cnt % 4;
            if (phase_cnt == 2)
                hold_req = 1'b1;
            wmax = sb.clamp_dim(sb.width_q);
            hmax = sb.clamp_dim(sb.height_q);
            for (int k = 0; k < 150; k++) begin
                if ($urandom_range(0, 9) < 8)
                    send_pixel(12'($urandom_range(0, wmax - 1)),
                               12'($urandom_range(0, hmax - 1)));
                else
                    send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
                sent++;
                burst = $urandom_range(0, 15);
                if (phase_cnt % 3 != 0 && burst == 0)
                    pause_input($urandom_range(1, 6));
            end
            drain();
            phase_cnt++;
        end

        // wait out anything still in flight
        stall_mode = 0;
        repeat (LATENCY) @(posedge i_clk);
        if (sb.level_q.size() != 0)
            sb.report($sformatf("%0d levels never arrived", sb.level_q.size()));
        $display("tb: %0d pixels checked over %0d random settings, %0d register writes",
                 sb.checked, phase_cnt, cfg_writes);
        $display("tb: included clamped sizes, zero and full-scale focus, extreme gains");
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
